/* rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared widths, codes, control word layout and microprogram of the
// first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int SLOTS    = 16;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int SIZE_W   = 5;
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 2;
  localparam int START_W  = 4;
  localparam int FREE_W   = 5;
  localparam int CMP_W    = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;
  localparam int TAG_W    = (IDX_W > HANDLE_W) ? IDX_W : HANDLE_W;
  localparam int STEP_W   = 3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_SIZE_ZERO = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    C_NEVER      = 3'd0,
    C_ALWAYS     = 3'd1,
    C_ALLOC_ZERO = 3'd2,
    C_OP_FREE    = 3'd3,
    C_HIT        = 3'd4,
    C_MISS_END   = 3'd5,
    C_MARK_LAST  = 3'd6,
    C_LAST       = 3'd7
  } cond_t;

  typedef enum logic [1:0] {
    DP_NOP  = 2'd0,
    DP_SCAN = 2'd1,
    DP_MARK = 2'd2,
    DP_FREE = 2'd3
  } dp_op_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t U_CHK_ZERO = 3'd0;
  localparam step_t U_CHK_OP   = 3'd1;
  localparam step_t U_SCAN     = 3'd2;
  localparam step_t U_MARK     = 3'd3;
  localparam step_t U_FREE     = 3'd4;
  localparam step_t U_DONE     = 3'd5;
  localparam step_t U_NO_SPACE = 3'd6;
  localparam step_t U_REJECT   = 3'd7;

  typedef struct packed {
    cond_t   jmp_cond;
    step_t   jmp_target;
    cond_t   adv_cond;
    dp_op_t  dp_op;
    logic    emit;
    status_t status;
    logic    fin;
  } uword_t;

  typedef struct packed {
    logic alloc_zero;
    logic op_free;
    logic hit;
    logic miss_end;
    logic mark_last;
    logic last;
  } dp_flags_t;

  // Next step: jump on jmp_cond, else advance on adv_cond, else hold.
  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    unique case (step)
      U_CHK_ZERO: w = '{C_ALLOC_ZERO, U_REJECT, C_ALWAYS, DP_NOP, 1'b0, ST_DONE, 1'b0};
      U_CHK_OP:   w = '{C_OP_FREE, U_FREE, C_ALWAYS, DP_NOP, 1'b0, ST_DONE, 1'b0};
      U_SCAN:     w = '{C_MISS_END, U_NO_SPACE, C_HIT, DP_SCAN, 1'b0, ST_DONE, 1'b0};
      U_MARK:     w = '{C_MARK_LAST, U_DONE, C_NEVER, DP_MARK, 1'b0, ST_DONE, 1'b0};
      U_FREE:     w = '{C_LAST, U_DONE, C_NEVER, DP_FREE, 1'b0, ST_DONE, 1'b0};
      U_DONE:     w = '{C_NEVER, U_CHK_ZERO, C_NEVER, DP_NOP, 1'b1, ST_DONE, 1'b1};
      U_NO_SPACE: w = '{C_NEVER, U_CHK_ZERO, C_NEVER, DP_NOP, 1'b1, ST_NO_SPACE, 1'b1};
      U_REJECT:   w = '{C_NEVER, U_CHK_ZERO, C_NEVER, DP_NOP, 1'b1, ST_SIZE_ZERO, 1'b1};
    endcase
    return w;
  endfunction

endpackage

/* rtl/ffba_sequencer.sv */
// ----------------------------------------------------------------------------
// ffba_sequencer
// Step counter, microprogram table and jump logic of the allocator.
// ----------------------------------------------------------------------------
module ffba_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  ffba_pkg::dp_flags_t flags,
  output ffba_pkg::uword_t    ctl,
  output logic                busy
);

  logic             busy_r, busy_nxt;
  ffba_pkg::step_t  step_r, step_nxt;
  ffba_pkg::uword_t word;

  function automatic logic cond_met(input ffba_pkg::cond_t c, input ffba_pkg::dp_flags_t f);
    logic m;
    unique case (c)
      ffba_pkg::C_NEVER:      m = 1'b0;
      ffba_pkg::C_ALWAYS:     m = 1'b1;
      ffba_pkg::C_ALLOC_ZERO: m = f.alloc_zero;
      ffba_pkg::C_OP_FREE:    m = f.op_free;
      ffba_pkg::C_HIT:        m = f.hit;
      ffba_pkg::C_MISS_END:   m = f.miss_end;
      ffba_pkg::C_MARK_LAST:  m = f.mark_last;
      ffba_pkg::C_LAST:       m = f.last;
    endcase
    return m;
  endfunction

  always_comb begin
    word     = ffba_pkg::ucode_rom(step_r);
    ctl      = word;
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      // idle: drive no datapath operation
      ctl.dp_op = ffba_pkg::DP_NOP;
      ctl.emit  = 1'b0;
      ctl.fin   = 1'b0;
      if (accept) begin
        busy_nxt = 1'b1;
        step_nxt = ffba_pkg::U_CHK_ZERO;
      end
    end else begin
      if (word.fin) begin
        busy_nxt = 1'b0;
      end
      if (cond_met(word.jmp_cond, flags)) begin
        step_nxt = word.jmp_target;
      end else if (cond_met(word.adv_cond, flags)) begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= ffba_pkg::U_CHK_ZERO;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  assign busy = busy_r;

endmodule

/* rtl/ffba_datapath.sv */
// ----------------------------------------------------------------------------
// ffba_datapath
// Slot table, scan counters and result registers of the allocator.
// ----------------------------------------------------------------------------
module ffba_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic                              in_operation,
  input  logic [ffba_pkg::SIZE_W-1:0]       in_size,
  input  logic [ffba_pkg::HANDLE_W-1:0]     in_handle,
  input  ffba_pkg::uword_t                  ctl,
  output ffba_pkg::dp_flags_t               flags,
  output logic                              out_valid,
  output logic [ffba_pkg::STATUS_W-1:0]     out_status,
  output logic [ffba_pkg::START_W-1:0]      out_start_slot,
  output logic [ffba_pkg::FREE_W-1:0]       out_free_count
);

  logic [ffba_pkg::SLOTS-1:0]       used_r;
  logic [ffba_pkg::IDX_W-1:0]       owner_r [ffba_pkg::SLOTS];
  logic [ffba_pkg::CNT_W-1:0]       free_cnt_r;
  logic                             op_r;
  logic [ffba_pkg::SIZE_W-1:0]      size_r;
  logic [ffba_pkg::HANDLE_W-1:0]    handle_r;
  logic [ffba_pkg::IDX_W-1:0]       idx_r;
  logic [ffba_pkg::CNT_W-1:0]       run_r;
  logic [ffba_pkg::IDX_W-1:0]       start_r;
  logic                             out_valid_r;
  logic [ffba_pkg::STATUS_W-1:0]    out_status_r;
  logic [ffba_pkg::START_W-1:0]     out_start_r;
  logic [ffba_pkg::FREE_W-1:0]      out_free_r;

  logic                             used_cur;
  logic [ffba_pkg::CMP_W-1:0]       run_inc;
  logic [ffba_pkg::CMP_W-1:0]       size_ext;
  logic [ffba_pkg::IDX_W-1:0]       start_calc;
  logic                             tag_match;
  logic                             hit;
  logic                             last;

  always_comb begin
    used_cur   = used_r[idx_r];
    run_inc    = ffba_pkg::CMP_W'(run_r) + ffba_pkg::CMP_W'(1);
    size_ext   = ffba_pkg::CMP_W'(size_r);
    hit        = !used_cur && (run_inc == size_ext);
    last       = (idx_r == ffba_pkg::IDX_W'(ffba_pkg::SLOTS - 1));
    start_calc = ffba_pkg::IDX_W'(ffba_pkg::CMP_W'(idx_r) + ffba_pkg::CMP_W'(1) - size_ext);
    tag_match  = (ffba_pkg::TAG_W'(owner_r[idx_r]) == ffba_pkg::TAG_W'(handle_r));

    flags.alloc_zero = (op_r == ffba_pkg::OP_ALLOC) && (size_r == '0);
    flags.op_free    = (op_r == ffba_pkg::OP_FREE);
    flags.hit        = hit;
    flags.miss_end   = !hit && last;
    flags.mark_last  = (run_r == ffba_pkg::CNT_W'(1));
    flags.last       = last;
  end

  // occupancy and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      free_cnt_r  <= ffba_pkg::CNT_W'(ffba_pkg::SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
      case (ctl.dp_op)
        ffba_pkg::DP_MARK: begin
          used_r[idx_r] <= 1'b1;
          free_cnt_r    <= free_cnt_r - 1'b1;
        end
        ffba_pkg::DP_FREE: begin
          if (used_cur && tag_match) begin
            used_r[idx_r] <= 1'b0;
            free_cnt_r    <= free_cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // request, scan state, tags and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      size_r   <= in_size;
      handle_r <= in_handle;
      idx_r    <= '0;
      run_r    <= '0;
      start_r  <= '0;
    end
    case (ctl.dp_op)
      ffba_pkg::DP_SCAN: begin
        if (hit) begin
          // rewind to the run start and count its length down while tagging
          start_r <= start_calc;
          idx_r   <= start_calc;
          run_r   <= ffba_pkg::CNT_W'(size_r);
        end else begin
          run_r <= used_cur ? '0 : ffba_pkg::CNT_W'(run_inc);
          idx_r <= idx_r + 1'b1;
        end
      end
      ffba_pkg::DP_MARK: begin
        owner_r[idx_r] <= start_r;
        idx_r          <= idx_r + 1'b1;
        run_r          <= run_r - 1'b1;
      end
      ffba_pkg::DP_FREE: begin
        idx_r <= idx_r + 1'b1;
      end
      default: ;
    endcase
    if (ctl.emit) begin
      out_status_r <= ctl.status;
      out_start_r  <= ffba_pkg::START_W'(start_r);
      out_free_r   <= ffba_pkg::FREE_W'(free_cnt_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_start_slot = out_start_r;
  assign out_free_count = out_free_r;

endmodule

/* rtl/first_fit_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit contiguous slot allocator with a microcoded control sequencer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result follows
// on out_valid for a single cycle and cannot be held off, so capture it then.
// Each request walks a microprogram; its scan, mark and free steps visit one
// slot per cycle. An allocate scans to the end of the first free run of its
// size, then rewinds to the run start and marks the run; one that finds no
// run scans every slot. A free visits every slot, and an allocate of size
// zero is rejected before any scan. busy falls with the strobe, and the next
// request may be taken in that same cycle.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_operation,
  input  logic [ffba_pkg::SIZE_W-1:0]       in_size,
  input  logic [ffba_pkg::HANDLE_W-1:0]     in_handle,
  output logic                              out_valid,
  output logic [ffba_pkg::STATUS_W-1:0]     out_status,
  output logic [ffba_pkg::START_W-1:0]      out_start_slot,
  output logic [ffba_pkg::FREE_W-1:0]       out_free_count
);

  logic                accept;
  ffba_pkg::uword_t    ctl;
  ffba_pkg::dp_flags_t flags;

  assign accept = start && !busy;

  ffba_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .flags  (flags),
    .ctl    (ctl),
    .busy   (busy)
  );

  ffba_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_operation   (in_operation),
    .in_size        (in_size),
    .in_handle      (in_handle),
    .ctl            (ctl),
    .flags          (flags),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_start_slot (out_start_slot),
    .out_free_count (out_free_count)
  );

  // result strobe and end of sequence coincide
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequence still running");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("transfer did not start a sequence");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_free_count <= ffba_pkg::FREE_W'(ffba_pkg::SLOTS)))
    else $error("free count beyond table size");

  a_fail_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ffba_pkg::ST_DONE)) |-> (out_start_slot == '0))
    else $error("nonzero start slot on failed allocate");

endmodule

/* sim/tb_first_fit_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_unit
// Self-checking bench for the first-fit block allocator. A directed table
// covers the edge cases: size zero, oversize requests, a full table, unknown
// handles and first-fit hole reuse. A long random run follows, built mostly
// from frees of live blocks and small allocations. A shadow slot table
// predicts each non-fixed reply; each strobed reply is compared per field.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 830;
  localparam int DRAIN_CYCLES = 2 * ffba_pkg::SLOTS + 10;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    ffba_pkg::status_t              status;
    logic [ffba_pkg::START_W-1:0]   start_slot;
    logic [ffba_pkg::FREE_W-1:0]    free_count;
  } reply_t;

  typedef struct {
    logic                           op;
    logic [ffba_pkg::SIZE_W-1:0]    size;
    logic [ffba_pkg::HANDLE_W-1:0]  handle;
    bit                             fixed;
    ffba_pkg::status_t              status;
    logic [ffba_pkg::START_W-1:0]   start_slot;
    logic [ffba_pkg::FREE_W-1:0]    free_count;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  // Rows marked fixed carry their reply; the rest use the slot table shadow.
  dir_row_t dir_table [DIR_ROWS] = '{
    '{ffba_pkg::OP_ALLOC, 5'd0,  4'd0,  1'b1, ffba_pkg::ST_SIZE_ZERO, 4'd0, 5'd16},
    '{ffba_pkg::OP_ALLOC, 5'd17, 4'd15, 1'b1, ffba_pkg::ST_NO_SPACE,  4'd0, 5'd16},
    '{ffba_pkg::OP_ALLOC, 5'd31, 4'd0,  1'b1, ffba_pkg::ST_NO_SPACE,  4'd0, 5'd16},
    '{ffba_pkg::OP_FREE,  5'd0,  4'd0,  1'b1, ffba_pkg::ST_DONE,      4'd0, 5'd16},
    '{ffba_pkg::OP_ALLOC, 5'd16, 4'd9,  1'b1, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_ALLOC, 5'd1,  4'd0,  1'b1, ffba_pkg::ST_NO_SPACE,  4'd0, 5'd0},
    '{ffba_pkg::OP_ALLOC, 5'd0,  4'd15, 1'b1, ffba_pkg::ST_SIZE_ZERO, 4'd0, 5'd0},
    '{ffba_pkg::OP_FREE,  5'd0,  4'd15, 1'b1, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_FREE,  5'd31, 4'd0,  1'b1, ffba_pkg::ST_DONE,      4'd0, 5'd16},
    '{ffba_pkg::OP_ALLOC, 5'd1,  4'd15, 1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_ALLOC, 5'd3,  4'd0,  1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_ALLOC, 5'd2,  4'd0,  1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_ALLOC, 5'd4,  4'd0,  1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_FREE,  5'd0,  4'd1,  1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_ALLOC, 5'd2,  4'd0,  1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_ALLOC, 5'd2,  4'd0,  1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_ALLOC, 5'd1,  4'd0,  1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_ALLOC, 5'd4,  4'd0,  1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_FREE,  5'd31, 4'd4,  1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_FREE,  5'd16, 4'd12, 1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_ALLOC, 5'd6,  4'd0,  1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_ALLOC, 5'd4,  4'd0,  1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0},
    '{ffba_pkg::OP_FREE,  5'd0,  4'd14, 1'b0, ffba_pkg::ST_DONE,      4'd0, 5'd0}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic                           in_operation;
  logic [ffba_pkg::SIZE_W-1:0]    in_size;
  logic [ffba_pkg::HANDLE_W-1:0]  in_handle;
  logic                           out_valid;
  logic [ffba_pkg::STATUS_W-1:0]  out_status;
  logic [ffba_pkg::START_W-1:0]   out_start_slot;
  logic [ffba_pkg::FREE_W-1:0]    out_free_count;

  bit                             shadow_used  [ffba_pkg::SLOTS];
  logic [ffba_pkg::TAG_W-1:0]     shadow_owner [ffba_pkg::SLOTS];
  reply_t                         awaited_replies [$];
  int                             fail_cnt;
  int                             cycle_count;
  bit                             no_gaps;

  first_fit_block_allocator_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_size        (in_size),
    .in_handle      (in_handle),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_start_slot (out_start_slot),
    .out_free_count (out_free_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the shadow table and return the reply it produces.
  function automatic reply_t update_slot_table(input logic op,
                                               input logic [ffba_pkg::SIZE_W-1:0] sz,
                                               input logic [ffba_pkg::HANDLE_W-1:0] hd);
    reply_t r;
    int     run;
    int     first;
    int     i;
    int     n_free;
    bit     found;
    r.status     = ffba_pkg::ST_DONE;
    r.start_slot = '0;
    if (op == ffba_pkg::OP_ALLOC) begin
      if (sz == '0) begin
        r.status = ffba_pkg::ST_SIZE_ZERO;
      end else begin
        run   = 0;
        first = 0;
        found = 1'b0;
        for (i = 0; i < ffba_pkg::SLOTS && !found; i++) begin
          run = shadow_used[i] ? 0 : run + 1;
          if (run == int'(sz)) begin
            first = i + 1 - int'(sz);
            found = 1'b1;
          end
        end
        if (found) begin
          for (i = first; i < first + int'(sz); i++) begin
            shadow_used[i]  = 1'b1;
            shadow_owner[i] = ffba_pkg::TAG_W'(first);
          end
          r.start_slot = ffba_pkg::START_W'(first);
        end else begin
          r.status = ffba_pkg::ST_NO_SPACE;
        end
      end
    end else begin
      for (i = 0; i < ffba_pkg::SLOTS; i++) begin
        if (shadow_used[i] && shadow_owner[i] == ffba_pkg::TAG_W'(hd)) begin
          shadow_used[i]  = 1'b0;
          shadow_owner[i] = '0;
        end
      end
    end
    n_free = 0;
    for (i = 0; i < ffba_pkg::SLOTS; i++) begin
      if (!shadow_used[i]) n_free++;
    end
    r.free_count = ffba_pkg::FREE_W'(n_free);
    return r;
  endfunction

  // Pick the start of a live block, or a random handle when none is live.
  function automatic logic [ffba_pkg::HANDLE_W-1:0] pick_live_handle();
    int starts [$];
    int i;
    for (i = 0; i < ffba_pkg::SLOTS; i++) begin
      if (shadow_used[i] && int'(shadow_owner[i]) == i) starts.push_back(i);
    end
    if (starts.size() == 0) return ffba_pkg::HANDLE_W'($urandom_range(0, 15));
    return ffba_pkg::HANDLE_W'(starts[$urandom_range(0, starts.size() - 1)]);
  endfunction

  task automatic send_request(input logic op, input logic [ffba_pkg::SIZE_W-1:0] sz,
                              input logic [ffba_pkg::HANDLE_W-1:0] hd, input bit fixed,
                              input reply_t fixed_reply);
    int     gap;
    reply_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_size      <= sz;
    in_handle    <= hd;
    // hold until the transfer edge
    do @(posedge clk); while (busy);
    r = update_slot_table(op, sz, hd);
    awaited_replies.push_back(fixed ? fixed_reply : r);
  endtask

  initial begin
    reply_t                         fr;
    int                             k;
    int                             pick;
    logic                           op;
    logic [ffba_pkg::SIZE_W-1:0]    sz;
    logic [ffba_pkg::HANDLE_W-1:0]  hd;
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = ffba_pkg::OP_ALLOC;
    in_size      = '0;
    in_handle    = '0;
    fail_cnt     = 0;
    no_gaps      = 1'b0;
    for (k = 0; k < ffba_pkg::SLOTS; k++) begin
      shadow_used[k]  = 1'b0;
      shadow_owner[k] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[row]) begin
      fr.status     = dir_table[row].status;
      fr.start_slot = dir_table[row].start_slot;
      fr.free_count = dir_table[row].free_count;
      send_request(dir_table[row].op, dir_table[row].size, dir_table[row].handle,
                   dir_table[row].fixed, fr);
    end

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      // alternate stretches of back-to-back requests with gapped ones
      if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (k == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      hd   = ffba_pkg::HANDLE_W'($urandom_range(0, 15));
      sz   = ffba_pkg::SIZE_W'($urandom_range(0, 31));
      if (pick < 40) begin
        op = ffba_pkg::OP_ALLOC;
        sz = ffba_pkg::SIZE_W'($urandom_range(1, 5));
      end else if (pick < 52) begin
        op = ffba_pkg::OP_ALLOC;
        sz = ffba_pkg::SIZE_W'($urandom_range(1, ffba_pkg::SLOTS));
      end else if (pick < 58) begin
        op = ffba_pkg::OP_ALLOC;
      end else if (pick < 90) begin
        op = ffba_pkg::OP_FREE;
        hd = pick_live_handle();
      end else begin
        op = ffba_pkg::OP_FREE;
      end
      send_request(op, sz, hd, 1'b0, fr);
    end

    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Compare each strobed reply against the oldest awaited one.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid) begin
      if (awaited_replies.size() == 0) begin
        $error("unexpected reply: status %0d start_slot %0d free_count %0d",
               out_status, out_start_slot, out_free_count);
        fail_cnt++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          fail_cnt++;
        end
        if (out_start_slot !== want.start_slot) begin
          $error("start_slot: expected %0d, actual %0d", want.start_slot, out_start_slot);
          fail_cnt++;
        end
        if (out_free_count !== want.free_count) begin
          $error("free_count: expected %0d, actual %0d", want.free_count, out_free_count);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
